// ----- hw/rtl/plid_pkg.sv -----
package plid_pkg;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_DELETE = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_POS = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic check;
      logic rd_pos;
      logic rd_move;
      logic wr_move;
      logic wr_value;
      logic cap_removed;
      logic commit;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic error;
      logic is_delete;
      logic more;
      logic out_free;
   } sts_type;

endpackage

// ----- hw/rtl/positional_list_insert_delete.sv -----
// steps: an error goes from check to result; insert moves m = count-p+1 entries, then writes the value;
// delete reads and captures entry p, then moves m = count-p entries (moves between entries)
// one request at a time; each entry move is a registered read of the store, then a write,
// and the next request can be taken in the cycle after commit
// reset clears the count and the response valid; store contents are left as they are
module positional_list_insert_delete #(
   parameter int CAPACITY   = 128,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_position,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_removed_value,
   output logic [7:0]  rsp_count
);
   import plid_pkg::*;

   cmd_type cmd;
   sts_type sts;

   plid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   plid_dpath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_mode          (req_mode),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_count         (rsp_count),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule

// ----- hw/rtl/plid_ctrl.sv -----
module plid_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  plid_pkg::sts_type sts,
   output plid_pkg::cmd_type cmd
);
   import plid_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b00000001,
      ST_CHECK   = 8'b00000010,
      ST_DEL_RD  = 8'b00000100,
      ST_DEL_CAP = 8'b00001000,
      ST_MV_RD   = 8'b00010000,
      ST_MV_WR   = 8'b00100000,
      ST_INS_WR  = 8'b01000000,
      ST_DONE    = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (sts.error) begin
               state_in = ST_DONE;
            end else if (sts.is_delete) begin
               state_in = ST_DEL_RD;
            end else begin
               state_in = ST_MV_RD;
            end
         end
         ST_DEL_RD: begin
            cmd.rd_pos = 1'b1;
            state_in   = ST_DEL_CAP;
         end
         ST_DEL_CAP: begin
            cmd.cap_removed = 1'b1;
            state_in        = ST_MV_RD;
         end
         ST_MV_RD: begin
            if (sts.more) begin
               cmd.rd_move = 1'b1;
               state_in    = ST_MV_WR;
            end else if (sts.is_delete) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_INS_WR;
            end
         end
         ST_MV_WR: begin
            cmd.wr_move = 1'b1;
            state_in    = ST_MV_RD;
         end
         ST_INS_WR: begin
            cmd.wr_value = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            // wait until the response register can take the result
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/plid_dpath.sv -----
module plid_dpath #(
   parameter int CAPACITY   = 128,
   parameter int DATA_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_mode,
   input  logic [7:0]        req_position,
   input  logic [31:0]       req_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [31:0]       rsp_removed_value,
   output logic [7:0]        rsp_count,
   input  plid_pkg::cmd_type cmd,
   output plid_pkg::sts_type sts
);
   import plid_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int XW = ((CW > 8) ? CW : 8) + 1;

   logic [DATA_WIDTH-1:0] mem_ff [CAPACITY];
   logic [DATA_WIDTH-1:0] rdata_ff;

   logic                  mode_ff;
   logic [7:0]            pos_ff;
   logic [DATA_WIDTH-1:0] val_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         ptr_ff, ptr_in;
   logic [1:0]            status_ff, status_in;
   logic [DATA_WIDTH-1:0] removed_ff, removed_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff;
   logic [31:0]           rsp_removed_ff;
   logic [7:0]            rsp_count_ff;

   logic                  ins;
   logic [XW-1:0]         pos_x, cnt_x, ptr_x;
   logic                  bad_pos, full;
   logic [AW-1:0]         pos_addr, mv_rd_addr, mv_wr_addr, rd_addr;

   assign ins   = (mode_ff == MODE_INSERT);
   assign pos_x = XW'(pos_ff);
   assign cnt_x = XW'(count_ff);
   assign ptr_x = XW'(ptr_ff);

   assign bad_pos = (pos_x == '0) ||
                    (ins ? (pos_x > cnt_x + XW'(1)) : (pos_x > cnt_x));
   assign full    = ins && (count_ff == CW'(CAPACITY));

   // insert walks down from the tail, delete walks up from the hole
   assign pos_addr   = AW'(pos_ff - 8'd1);
   assign mv_rd_addr = ins ? AW'(ptr_ff - CW'(1)) : AW'(ptr_ff);
   assign mv_wr_addr = ins ? AW'(ptr_ff) : AW'(ptr_ff - CW'(1));
   assign rd_addr    = cmd.rd_pos ? pos_addr : mv_rd_addr;

   assign sts.error     = bad_pos || full;
   assign sts.is_delete = !ins;
   assign sts.more      = ins ? (ptr_x >= pos_x) : (ptr_x < cnt_x);
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.wr_move) begin
         mem_ff[mv_wr_addr] <= rdata_ff;
      end else if (cmd.wr_value) begin
         mem_ff[pos_addr] <= val_ff;
      end
      if (cmd.rd_pos || cmd.rd_move) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.check) begin
         ptr_in = ins ? count_ff : CW'(pos_ff);
      end else if (cmd.wr_move) begin
         ptr_in = ins ? (ptr_ff - CW'(1)) : (ptr_ff + CW'(1));
      end
   end

   always_comb begin
      status_in = status_ff;
      if (cmd.check) begin
         if (bad_pos) begin
            status_in = STATUS_BAD_POS;
         end else if (full) begin
            status_in = STATUS_FULL;
         end else begin
            status_in = STATUS_OK;
         end
      end
   end

   always_comb begin
      removed_in = removed_ff;
      if (cmd.load) begin
         removed_in = '0;
      end else if (cmd.cap_removed) begin
         removed_in = rdata_ff;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.commit && (status_ff == STATUS_OK)) begin
         count_in = ins ? (count_ff + CW'(1)) : (count_ff - CW'(1));
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         pos_ff  <= req_position;
         val_ff  <= DATA_WIDTH'(req_value);
      end
      ptr_ff     <= ptr_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      if (cmd.commit) begin
         rsp_status_ff  <= status_ff;
         rsp_removed_ff <= 32'(removed_ff);
         rsp_count_ff   <= 8'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_count         = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("list count above capacity");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result committed over a pending response");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed result not presented");

   a_count_on_commit: assert property (@(posedge clock) disable iff (reset)
      !cmd.commit |=> $stable(count_ff))
      else $error("count changed outside commit");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_move && cmd.wr_value))
      else $error("two store writes in one cycle");
`endif

endmodule

// ----- tb/positional_list_insert_delete_check.sv -----
`timescale 1ns / 100ps

module positional_list_insert_delete_check #(
   parameter int CAPACITY   = 128,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_position,
   input  logic [31:0] req_value,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [31:0] rsp_removed_value,
   input  logic [7:0]  rsp_count,
   output int          error_count,
   output int          pending_count,
   output int          ok_count,
   output int          bad_pos_count,
   output int          full_count
);
   import plid_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] removed;
      logic [7:0]  count;
   } list_outcome_type;

   logic [DATA_WIDTH-1:0] list_store [CAPACITY];
   int                    list_len;
   list_outcome_type      outcome_fifo [$];
   list_outcome_type      predicted;
   list_outcome_type      observed;
   list_outcome_type      oldest;

   // applies one request to the shadow list and returns what the block must answer
   task automatic apply_list_op(input logic mode, input logic [7:0] position,
                                input logic [31:0] value, output list_outcome_type res);
      int p;
      int k;
      p = position;
      res.status = STATUS_OK;
      res.removed = '0;
      if (mode == MODE_INSERT) begin
         if (p < 1 || p > list_len + 1) begin
            res.status = STATUS_BAD_POS;
         end else if (list_len >= CAPACITY) begin
            res.status = STATUS_FULL;
         end else begin
            for (k = list_len; k >= p; k--) list_store[k] = list_store[k-1];
            list_store[p-1] = DATA_WIDTH'(value);
            list_len++;
         end
      end else begin
         if (p < 1 || p > list_len) begin
            res.status = STATUS_BAD_POS;
         end else begin
            res.removed = 32'(list_store[p-1]);
            for (k = p; k < list_len; k++) list_store[k-1] = list_store[k];
            list_len--;
         end
      end
      res.count = 8'(list_len);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         list_len = 0;
         outcome_fifo.delete();
         error_count <= 0;
         pending_count <= 0;
         ok_count <= 0;
         bad_pos_count <= 0;
         full_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_list_op(req_mode, req_position, req_value, predicted);
            outcome_fifo.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            observed = '{rsp_status, rsp_removed_value, rsp_count};
            case (rsp_status)
               STATUS_OK:      ok_count <= ok_count + 1;
               STATUS_BAD_POS: bad_pos_count <= bad_pos_count + 1;
               STATUS_FULL:    full_count <= full_count + 1;
               default: ;
            endcase
            if (outcome_fifo.size() == 0) begin
               if (error_count < 10)
                  $display("unexpected response: status %0d removed %h count %0d",
                           rsp_status, rsp_removed_value, rsp_count);
               error_count <= error_count + 1;
            end else begin
               oldest = outcome_fifo.pop_front();
               if (observed.status !== oldest.status || observed.removed !== oldest.removed ||
                   observed.count !== oldest.count) begin
                  if (error_count < 10)
                     $display("mismatch: expected status %0d removed %h count %0d,",
                              oldest.status, oldest.removed, oldest.count,
                              " got status %0d removed %h count %0d",
                              observed.status, observed.removed, observed.count);
                  error_count <= error_count + 1;
               end
            end
         end
         pending_count <= outcome_fifo.size();
      end
   end

endmodule

// ----- tb/positional_list_insert_delete_test.sv -----
`timescale 1ns / 100ps

module positional_list_insert_delete_test;
   import plid_pkg::*;

   localparam int CAPACITY   = 128;
   localparam int DATA_WIDTH = 32;
   localparam int IDLE_LIMIT = 3000;
   localparam int HOLD_LEN   = 400;
   localparam int DRAIN_WAIT = 300;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_mode;
   logic [7:0]  req_position;
   logic [31:0] req_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_removed_value;
   logic [7:0]  rsp_count;

   int error_count;
   int pending_count;
   int ok_count;
   int bad_pos_count;
   int full_count;

   int req_idle_pct;
   int rsp_idle_pct;
   int hold_request;
   int gen_len;
   int sent_count;
   int insert_count;
   int delete_count;
   int fill_count;
   int quiet_cycles;

   positional_list_insert_delete #(
      .CAPACITY  (CAPACITY),
      .DATA_WIDTH(DATA_WIDTH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_position     (req_position),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_removed_value(rsp_removed_value),
      .rsp_count        (rsp_count)
   );

   positional_list_insert_delete_check #(
      .CAPACITY  (CAPACITY),
      .DATA_WIDTH(DATA_WIDTH)
   ) u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_position     (req_position),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_removed_value(rsp_removed_value),
      .rsp_count        (rsp_count),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .ok_count         (ok_count),
      .bad_pos_count    (bad_pos_count),
      .full_count       (full_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // watchdog on cycles where neither channel moves
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // response side: random stall plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input logic mode, input int pos, input logic [31:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_position <= 8'(pos);
      req_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent_count++;
      if (mode == MODE_INSERT) begin
         insert_count++;
         if (pos >= 1 && pos <= gen_len + 1 && gen_len < CAPACITY) gen_len++;
      end else begin
         delete_count++;
         if (pos >= 1 && pos <= gen_len) gen_len--;
      end
   endtask

   task automatic send_noise();
      send_request(logic'($urandom_range(1)), $urandom_range(255), $urandom());
   endtask

   // mostly appends, some inserts in the middle, then pokes at the full store
   task automatic fill_list();
      int r;
      while (gen_len < CAPACITY) begin
         r = $urandom_range(99);
         if (r < 80) send_request(MODE_INSERT, gen_len + 1, $urandom());
         else if (r < 93) send_request(MODE_INSERT, $urandom_range(1, gen_len + 1), $urandom());
         else send_noise();
      end
      fill_count++;
      repeat ($urandom_range(3, 6))
         send_request(MODE_INSERT, $urandom_range(1, CAPACITY + 1), $urandom());
      // bad position wins over full
      send_request(MODE_INSERT, CAPACITY + 2, $urandom());
      send_request(MODE_INSERT, 0, $urandom());
      send_request(MODE_DELETE, CAPACITY + 1, $urandom());
   endtask

   task automatic drain_list();
      int r;
      while (gen_len > 0) begin
         r = $urandom_range(99);
         if (r < 80) send_request(MODE_DELETE, gen_len, $urandom());
         else if (r < 93) send_request(MODE_DELETE, $urandom_range(1, gen_len), $urandom());
         else send_noise();
      end
      send_request(MODE_DELETE, 1, $urandom());
      send_request(MODE_DELETE, 0, $urandom());
      send_request(MODE_INSERT, 2, $urandom());
   endtask

   // random traffic on a short list
   task automatic mix_list(input int target);
      logic mode;
      int   pos;
      int   r;
      while (sent_count < target) begin
         if (gen_len >= 24) mode = ($urandom_range(99) < 70) ? MODE_DELETE : MODE_INSERT;
         else if (gen_len == 0) mode = ($urandom_range(99) < 75) ? MODE_INSERT : MODE_DELETE;
         else mode = logic'($urandom_range(1));
         r = $urandom_range(99);
         if (r < 12) begin
            pos = $urandom_range(255);
         end else if (r < 30) begin
            case ($urandom_range(4))
               0: pos = 0;
               1: pos = 1;
               2: pos = gen_len;
               3: pos = gen_len + 1;
               default: pos = gen_len + 2;
            endcase
         end else if (mode == MODE_INSERT) begin
            pos = $urandom_range(1, gen_len + 1);
         end else begin
            pos = (gen_len > 0) ? $urandom_range(1, gen_len) : 1;
         end
         send_request(mode, pos, $urandom());
      end
   endtask

   initial begin
      int phase;
      int target;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_INSERT;
      req_position = '0;
      req_value = '0;
      req_idle_pct = 26;
      rsp_idle_pct = 58;
      hold_request = 0;
      gen_len = 0;
      sent_count = 0;
      insert_count = 0;
      delete_count = 0;
      fill_count = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty list, bad positions, front, middle and end
      send_request(MODE_DELETE, 1, 32'h0000_0000);
      send_request(MODE_DELETE, 0, 32'hFFFF_FFFF);
      send_request(MODE_INSERT, 0, 32'hDEAD_BEEF);
      send_request(MODE_INSERT, 2, 32'hDEAD_BEEF);
      send_request(MODE_INSERT, 1, 32'h0000_0000);
      send_request(MODE_INSERT, 1, 32'hFFFF_FFFF);
      send_request(MODE_INSERT, 3, 32'h8000_0001);
      send_request(MODE_INSERT, 2, 32'h1234_5678);
      send_request(MODE_INSERT, 255, 32'hA5A5_A5A5);
      send_request(MODE_INSERT, 6, 32'h5A5A_5A5A);
      send_request(MODE_DELETE, 5, 32'h0000_0000);
      send_request(MODE_DELETE, 255, 32'h0000_0000);
      send_request(MODE_DELETE, 1, 32'h0000_0000);
      send_request(MODE_DELETE, 3, 32'h0000_0000);
      send_request(MODE_INSERT, 2, 32'h5555_5555);
      send_request(MODE_DELETE, 2, 32'hFFFF_FFFF);
      send_request(MODE_DELETE, 1, 32'h0000_0000);
      send_request(MODE_DELETE, 1, 32'h0000_0000);
      send_request(MODE_DELETE, 1, 32'h0000_0000);

      // response side goes quiet while requests keep coming
      hold_request = HOLD_LEN;

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin req_idle_pct = 26; rsp_idle_pct = 58; end
            1: begin req_idle_pct = 58; rsp_idle_pct = 26; end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         target = sent_count + 594;
         fill_list();
         drain_list();
         mix_list(target);
         // let everything in flight come back before the next phase
         req_valid <= 1'b0;
         wait (pending_count == 0);
         @(negedge clock);
      end

      req_valid <= 1'b0;
      wait (pending_count == 0);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d requests (%0d inserts, %0d deletes), store filled %0d times",
               sent_count, insert_count, delete_count, fill_count);
      $display("responses: %0d ok, %0d bad position, %0d store full",
               ok_count, bad_pos_count, full_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
